@@ hw/rtl/bdti_pkg.sv @@
// bdti_pkg: shared constants, command and register codes, control struct
// for the binary delay table interpolator; no dependencies
package bdti_pkg;

   localparam int TABLE_BINS_DEF = 8192;
   localparam int TIME_W         = 64;
   localparam int VAL_W          = 32;
   localparam int PER_W          = 63;
   localparam int FRAC_W         = 32;
   localparam int CSR_IDX_W      = 3;

   localparam logic [1:0] CMD_EVAL   = 2'd0;
   localparam logic [1:0] CMD_WR_COS = 2'd1;
   localparam logic [1:0] CMD_WR_SIN = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_PERIOD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COS_AMP = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SIN_AMP = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DRIFT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_EPOCH   = 3'd4;

   localparam logic [PER_W-1:0] PERIOD_RESET = 63'h0000_0001_0000_0000;

   typedef struct packed {
      logic       valid;
      logic [1:0] cmd;
   } ctrl_type;

endpackage

@@ hw/rtl/binary_delay_table_interp.sv @@
// binary_delay_table_interp: top level, circular-orbit delay correction with
// table interpolation; uses bdti_pkg and bdti_phase
//
// One beat may be started every clock: busy never rises and the receiver
// cannot stall, so each result shows on rsp_valid for exactly one cycle.
// A start with command evaluate gives one result; table writes and the
// unused command give none. The path runs through the two bit-serial
// division chains: 64 stages for the floor modulo of time by the period and
// log2(TABLE_BINS)+32 stages for the phase position, followed by eight
// stages of table read, interpolation, split multiplies and the saturating
// sum. Table writes travel the same pipeline and land at the read stage, so
// results always see writes in beat order. The user must write registers
// through the csr_ channel only while no evaluate is in flight; the block
// does not enforce this. csr_ready is always high. Table entries that were
// never written read as undefined.
module binary_delay_table_interp #(
   parameter int TABLE_BINS = bdti_pkg::TABLE_BINS_DEF,
   localparam int AW = $clog2(TABLE_BINS + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   // command channel
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_command,
   input  logic [AW-1:0]                       req_table_index,
   input  logic signed [bdti_pkg::VAL_W-1:0]   req_table_value,
   input  logic signed [bdti_pkg::TIME_W-1:0]  req_arrival_time,
   // result channel
   output logic                                rsp_valid,
   output logic signed [bdti_pkg::TIME_W-1:0]  rsp_corrected_time,
   // register write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bdti_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bdti_pkg::TIME_W-1:0]         csr_wdata
);

   localparam int KW = $clog2(TABLE_BINS);
   localparam int TW = bdti_pkg::TIME_W;
   localparam int VW = bdti_pkg::VAL_W;
   localparam int FW = bdti_pkg::FRAC_W;
   localparam int AccW = 70;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // configuration registers
   logic [bdti_pkg::PER_W-1:0] period_ff;
   logic signed [TW-1:0]       cos_amp_ff, sin_amp_ff, drift_ff, epoch_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff  <= bdti_pkg::PERIOD_RESET;
         cos_amp_ff <= '0;
         sin_amp_ff <= '0;
         drift_ff   <= '0;
         epoch_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            bdti_pkg::REG_PERIOD:  period_ff  <= csr_wdata[bdti_pkg::PER_W-1:0];
            bdti_pkg::REG_COS_AMP: cos_amp_ff <= csr_wdata;
            bdti_pkg::REG_SIN_AMP: sin_amp_ff <= csr_wdata;
            bdti_pkg::REG_DRIFT:   drift_ff   <= csr_wdata;
            bdti_pkg::REG_EPOCH:   epoch_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // phase front end
   bdti_pkg::ctrl_type in_ctl, ph_ctl;
   logic [AW-1:0]      ph_idx;
   logic [VW-1:0]      ph_val;
   logic [TW-1:0]      ph_time;
   logic [KW-1:0]      ph_bin;
   logic [FW-1:0]      ph_frac;

   assign in_ctl.valid = start && !busy;
   assign in_ctl.cmd   = req_command;

   bdti_phase #(.TABLE_BINS(TABLE_BINS)) u_phase (
      .clock    (clock),
      .reset    (reset),
      .in_ctl   (in_ctl),
      .in_idx   (req_table_index),
      .in_val   (req_table_value),
      .in_time  (req_arrival_time),
      .period   (period_ff),
      .out_ctl  (ph_ctl),
      .out_idx  (ph_idx),
      .out_val  (ph_val),
      .out_time (ph_time),
      .out_bin  (ph_bin),
      .out_frac (ph_frac)
   );

   // table stores: two reads every beat, plus one write on a write beat
   logic [VW-1:0] cos_mem [0:TABLE_BINS];
   logic [VW-1:0] sin_mem [0:TABLE_BINS];
   logic          wr_ok;
   logic [AW-1:0] rd_lo, rd_hi;

   assign wr_ok = ph_ctl.valid && (ph_idx <= AW'(TABLE_BINS));
   assign rd_lo = AW'(ph_bin);
   assign rd_hi = AW'(ph_bin) + AW'(1);

   logic          e0_vld_ff;
   logic [VW-1:0] e0_clo_ff, e0_chi_ff, e0_slo_ff, e0_shi_ff;
   logic [FW-1:0] e0_frac_ff;
   logic [TW-1:0] e0_time_ff;

   always_ff @(posedge clock) begin
      if (wr_ok && (ph_ctl.cmd == bdti_pkg::CMD_WR_COS)) begin
         cos_mem[ph_idx] <= ph_val;
      end
      if (wr_ok && (ph_ctl.cmd == bdti_pkg::CMD_WR_SIN)) begin
         sin_mem[ph_idx] <= ph_val;
      end
      e0_clo_ff <= cos_mem[rd_lo];
      e0_chi_ff <= cos_mem[rd_hi];
      e0_slo_ff <= sin_mem[rd_lo];
      e0_shi_ff <= sin_mem[rd_hi];
   end

   always_ff @(posedge clock) begin
      e0_frac_ff <= ph_frac;
      e0_time_ff <= ph_time;
   end

   // valid chain for evaluate beats
   logic e1_vld_ff, e2_vld_ff, e3_vld_ff, e4_vld_ff, e5_vld_ff, e6_vld_ff, e7_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e0_vld_ff <= 1'b0;
         e1_vld_ff <= 1'b0;
         e2_vld_ff <= 1'b0;
         e3_vld_ff <= 1'b0;
         e4_vld_ff <= 1'b0;
         e5_vld_ff <= 1'b0;
         e6_vld_ff <= 1'b0;
         e7_vld_ff <= 1'b0;
      end else begin
         e0_vld_ff <= ph_ctl.valid && (ph_ctl.cmd == bdti_pkg::CMD_EVAL);
         e1_vld_ff <= e0_vld_ff;
         e2_vld_ff <= e1_vld_ff;
         e3_vld_ff <= e2_vld_ff;
         e4_vld_ff <= e3_vld_ff;
         e5_vld_ff <= e4_vld_ff;
         e6_vld_ff <= e5_vld_ff;
         e7_vld_ff <= e6_vld_ff;
      end
   end

   // stage 1: neighbor differences
   logic signed [VW-1:0] e1_clo_ff, e1_slo_ff;
   logic signed [VW:0]   e1_cd_ff, e1_sd_ff;
   logic [FW-1:0]        e1_frac_ff;
   logic [TW-1:0]        e1_time_ff;

   always_ff @(posedge clock) begin
      e1_clo_ff  <= $signed(e0_clo_ff);
      e1_slo_ff  <= $signed(e0_slo_ff);
      e1_cd_ff   <= (VW+1)'($signed(e0_chi_ff)) - (VW+1)'($signed(e0_clo_ff));
      e1_sd_ff   <= (VW+1)'($signed(e0_shi_ff)) - (VW+1)'($signed(e0_slo_ff));
      e1_frac_ff <= e0_frac_ff;
      e1_time_ff <= e0_time_ff;
   end

   // stage 2: difference times fraction
   localparam int IPW = VW + FW + 2;
   logic signed [VW-1:0]  e2_clo_ff, e2_slo_ff;
   logic signed [IPW-1:0] e2_cp_ff, e2_sp_ff;
   logic [TW-1:0]         e2_time_ff;

   always_ff @(posedge clock) begin
      e2_clo_ff  <= e1_clo_ff;
      e2_slo_ff  <= e1_slo_ff;
      e2_cp_ff   <= IPW'(e1_cd_ff) * IPW'($signed({1'b0, e1_frac_ff}));
      e2_sp_ff   <= IPW'(e1_sd_ff) * IPW'($signed({1'b0, e1_frac_ff}));
      e2_time_ff <= e1_time_ff;
   end

   // stage 3: interpolated values (floor), drift time difference
   logic signed [VW-1:0] e3_c_ff, e3_s_ff;
   logic signed [TW:0]   e3_diff_ff;
   logic signed [TW-1:0] e3_time_ff;
   logic signed [IPW-1:0] cp_sh, sp_sh;

   always_comb begin
      cp_sh = e2_cp_ff >>> FW;
      sp_sh = e2_sp_ff >>> FW;
   end

   always_ff @(posedge clock) begin
      e3_c_ff    <= e2_clo_ff + cp_sh[VW-1:0];
      e3_s_ff    <= e2_slo_ff + sp_sh[VW-1:0];
      e3_diff_ff <= (TW+1)'($signed(e2_time_ff)) - (TW+1)'(epoch_ff);
      e3_time_ff <= $signed(e2_time_ff);
   end

   // stage 4: split partial products, 33 bits at most per operand
   logic signed [63:0]   e4_cph_ff, e4_sph_ff;
   logic signed [64:0]   e4_cpl_ff, e4_spl_ff;
   logic [63:0]          e4_dll_ff;
   logic signed [65:0]   e4_dlh_ff, e4_dhl_ff;
   logic signed [64:0]   e4_dhh_ff;
   logic signed [TW-1:0] e4_time_ff;

   always_ff @(posedge clock) begin
      e4_cph_ff  <= 64'($signed(cos_amp_ff[63:32])) * 64'(e3_c_ff);
      e4_sph_ff  <= 64'($signed(sin_amp_ff[63:32])) * 64'(e3_s_ff);
      e4_cpl_ff  <= 65'($signed({1'b0, cos_amp_ff[31:0]})) * 65'(e3_c_ff);
      e4_spl_ff  <= 65'($signed({1'b0, sin_amp_ff[31:0]})) * 65'(e3_s_ff);
      e4_dll_ff  <= 64'(drift_ff[31:0]) * 64'(e3_diff_ff[31:0]);
      e4_dlh_ff  <= 66'($signed({1'b0, drift_ff[31:0]})) * 66'($signed(e3_diff_ff[64:32]));
      e4_dhl_ff  <= 66'($signed(drift_ff[63:32])) * 66'($signed({1'b0, e3_diff_ff[31:0]}));
      e4_dhh_ff  <= 65'($signed(drift_ff[63:32])) * 65'($signed(e3_diff_ff[64:32]));
      e4_time_ff <= e3_time_ff;
   end

   // stage 5: amplitude terms floored to q32.32, drift middle sum
   logic signed [96:0]  ct_full, st_full;
   logic signed [66:0]  e5_tc_ff, e5_ts_ff, e5_dmid_ff;
   logic [63:0]         e5_dll_ff;
   logic signed [64:0]  e5_dhh_ff;
   logic signed [TW-1:0] e5_time_ff;

   always_comb begin
      ct_full = ((97'(e4_cph_ff) <<< 32) + 97'(e4_cpl_ff)) >>> 30;
      st_full = ((97'(e4_sph_ff) <<< 32) + 97'(e4_spl_ff)) >>> 30;
   end

   always_ff @(posedge clock) begin
      e5_tc_ff   <= ct_full[66:0];
      e5_ts_ff   <= st_full[66:0];
      e5_dmid_ff <= 67'(e4_dlh_ff) + 67'(e4_dhl_ff);
      e5_dll_ff  <= e4_dll_ff;
      e5_dhh_ff  <= e4_dhh_ff;
      e5_time_ff <= e4_time_ff;
   end

   // stage 6: full drift product floored by 2^63, partial sum
   logic signed [129:0]   dsum;
   logic signed [66:0]    e6_td_ff;
   logic signed [AccW-1:0] e6_acc_ff;

   always_comb begin
      dsum = ((130'(e5_dhh_ff) <<< 64) + (130'(e5_dmid_ff) <<< 32)
              + 130'($signed({1'b0, e5_dll_ff}))) >>> 63;
   end

   always_ff @(posedge clock) begin
      e6_td_ff  <= dsum[66:0];
      e6_acc_ff <= AccW'(e5_time_ff) + AccW'(e5_tc_ff) + AccW'(e5_ts_ff);
   end

   // stage 7: subtract drift and saturate into the result register
   logic signed [AccW-1:0] acc;
   logic signed [TW-1:0]   sat;

   always_comb begin
      acc = e6_acc_ff - AccW'(e6_td_ff);
      if (acc[AccW-1:TW-1] == '0 || acc[AccW-1:TW-1] == '1) begin
         sat = acc[TW-1:0];
      end else begin
         sat = acc[AccW-1] ? {1'b1, {(TW-1){1'b0}}} : {1'b0, {(TW-1){1'b1}}};
      end
   end

   logic signed [TW-1:0] rsp_time_ff;

   always_ff @(posedge clock) begin
      rsp_time_ff <= sat;
   end

   assign rsp_valid          = e7_vld_ff;
   assign rsp_corrected_time = rsp_time_ff;

endmodule

@@ hw/rtl/bdti_phase.sv @@
// bdti_phase: pipelined floor modulo of time by the period, then phase position
// division giving table bin and fraction; uses bdti_pkg
module bdti_phase #(
   parameter int TABLE_BINS = bdti_pkg::TABLE_BINS_DEF,
   localparam int AW = $clog2(TABLE_BINS + 1),
   localparam int KW = $clog2(TABLE_BINS)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  bdti_pkg::ctrl_type               in_ctl,
   input  logic [AW-1:0]                    in_idx,
   input  logic [bdti_pkg::VAL_W-1:0]       in_val,
   input  logic [bdti_pkg::TIME_W-1:0]      in_time,
   input  logic [bdti_pkg::PER_W-1:0]       period,
   output bdti_pkg::ctrl_type               out_ctl,
   output logic [AW-1:0]                    out_idx,
   output logic [bdti_pkg::VAL_W-1:0]       out_val,
   output logic [bdti_pkg::TIME_W-1:0]      out_time,
   output logic [KW-1:0]                    out_bin,
   output logic [bdti_pkg::FRAC_W-1:0]      out_frac
);

   localparam int MS = bdti_pkg::TIME_W;
   localparam int PW = bdti_pkg::PER_W;
   localparam int TW = bdti_pkg::TIME_W;
   localparam int VW = bdti_pkg::VAL_W;
   localparam int DW = PW + KW;
   localparam int QW = KW + bdti_pkg::FRAC_W;

   // modulo chain
   bdti_pkg::ctrl_type m_ctl_ff [0:MS];
   logic [AW-1:0]      m_idx_ff [0:MS];
   logic [VW-1:0]      m_val_ff [0:MS];
   logic [TW-1:0]      m_time_ff [0:MS];
   logic [TW-1:0]      m_u_ff [0:MS];
   logic [PW-1:0]      m_rem_ff [0:MS];

   always_ff @(posedge clock) begin
      if (reset) begin
         m_ctl_ff[0] <= '0;
      end else begin
         m_ctl_ff[0] <= in_ctl;
      end
      m_idx_ff[0]  <= in_idx;
      m_val_ff[0]  <= in_val;
      m_time_ff[0] <= in_time;
      m_u_ff[0]    <= in_time[TW-1] ? (~in_time + TW'(1)) : in_time;
      m_rem_ff[0]  <= '0;
   end

   for (genvar j = 0; j < MS; j++) begin : g_mod
      logic [PW:0]   trial;
      logic [PW-1:0] rem_in;
      always_comb begin
         trial  = {m_rem_ff[j], m_u_ff[j][TW-1]};
         rem_in = (trial >= {1'b0, period}) ? PW'(trial - {1'b0, period}) : trial[PW-1:0];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            m_ctl_ff[j+1] <= '0;
         end else begin
            m_ctl_ff[j+1] <= m_ctl_ff[j];
         end
         m_idx_ff[j+1]  <= m_idx_ff[j];
         m_val_ff[j+1]  <= m_val_ff[j];
         m_time_ff[j+1] <= m_time_ff[j];
         m_u_ff[j+1]    <= {m_u_ff[j][TW-2:0], 1'b0};
         m_rem_ff[j+1]  <= rem_in;
      end
   end

   // floor remainder fix-up, then scale by bin count
   bdti_pkg::ctrl_type f_ctl_ff, d_ctl_ff;
   logic [AW-1:0]      f_idx_ff, d_idx_ff;
   logic [VW-1:0]      f_val_ff, d_val_ff;
   logic [TW-1:0]      f_time_ff, d_time_ff;
   logic [PW-1:0]      f_r_ff;
   logic [PW-1:0]      r_in;
   logic [DW-1:0]      d_num_ff;

   always_comb begin
      r_in = (m_time_ff[MS][TW-1] && (m_rem_ff[MS] != '0)) ? (period - m_rem_ff[MS])
                                                           : m_rem_ff[MS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_ctl_ff <= '0;
         d_ctl_ff <= '0;
      end else begin
         f_ctl_ff <= m_ctl_ff[MS];
         d_ctl_ff <= f_ctl_ff;
      end
      f_idx_ff  <= m_idx_ff[MS];
      f_val_ff  <= m_val_ff[MS];
      f_time_ff <= m_time_ff[MS];
      f_r_ff    <= r_in;
      d_idx_ff  <= f_idx_ff;
      d_val_ff  <= f_val_ff;
      d_time_ff <= f_time_ff;
      d_num_ff  <= DW'(f_r_ff) * DW'(TABLE_BINS);
   end

   // position division, one quotient bit per stage
   bdti_pkg::ctrl_type p_ctl_ff [0:QW];
   logic [AW-1:0]      p_idx_ff [0:QW];
   logic [VW-1:0]      p_val_ff [0:QW];
   logic [TW-1:0]      p_time_ff [0:QW];
   logic [PW-1:0]      p_rem_ff [0:QW];
   logic [KW-1:0]      p_low_ff [0:QW];
   logic [QW-1:0]      p_q_ff [0:QW];

   always_ff @(posedge clock) begin
      if (reset) begin
         p_ctl_ff[0] <= '0;
      end else begin
         p_ctl_ff[0] <= d_ctl_ff;
      end
      p_idx_ff[0]  <= d_idx_ff;
      p_val_ff[0]  <= d_val_ff;
      p_time_ff[0] <= d_time_ff;
      p_rem_ff[0]  <= d_num_ff[DW-1:KW];
      p_low_ff[0]  <= d_num_ff[KW-1:0];
      p_q_ff[0]    <= '0;
   end

   for (genvar n = 0; n < QW; n++) begin : g_pos
      logic          nbit;
      logic [PW:0]   trial;
      logic          ge;
      if (n < KW) begin : g_num
         assign nbit = p_low_ff[n][KW-1];
      end else begin : g_zero
         assign nbit = 1'b0;
      end
      always_comb begin
         trial = {p_rem_ff[n], nbit};
         ge    = (trial >= {1'b0, period});
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            p_ctl_ff[n+1] <= '0;
         end else begin
            p_ctl_ff[n+1] <= p_ctl_ff[n];
         end
         p_idx_ff[n+1]  <= p_idx_ff[n];
         p_val_ff[n+1]  <= p_val_ff[n];
         p_time_ff[n+1] <= p_time_ff[n];
         p_rem_ff[n+1]  <= ge ? PW'(trial - {1'b0, period}) : trial[PW-1:0];
         p_low_ff[n+1]  <= {p_low_ff[n][KW-2:0], 1'b0};
         p_q_ff[n+1]    <= {p_q_ff[n][QW-2:0], ge};
      end
   end

   // zero period means phase zero
   assign out_ctl  = p_ctl_ff[QW];
   assign out_idx  = p_idx_ff[QW];
   assign out_val  = p_val_ff[QW];
   assign out_time = p_time_ff[QW];
   assign out_bin  = (period == '0) ? '0 : p_q_ff[QW][QW-1:bdti_pkg::FRAC_W];
   assign out_frac = (period == '0) ? '0 : p_q_ff[QW][bdti_pkg::FRAC_W-1:0];

endmodule

@@ hw/rtl/bdti_checker.sv @@
// bdti_checker: port-level assertions for binary_delay_table_interp, bound
// to the top level; uses no package
module bdti_checker (
   input logic clock,
   input logic reset,
   input logic busy,
   input logic rsp_valid,
   input logic csr_valid,
   input logic csr_ready
);

   // no result may follow a reset cycle
   a_rsp_quiet_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result strobe right after reset");

   // command side never pushes back
   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   // register writes always taken
   a_csr_taken: assert property (@(posedge clock) disable iff (reset)
                                 csr_valid |-> csr_ready)
      else $error("register write not taken");

endmodule

bind binary_delay_table_interp bdti_checker u_bdti_checker (
   .clock     (clock),
   .reset     (reset),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready)
);

@@ dv/tb_binary_delay_table_interp.sv @@
// tb_binary_delay_table_interp: self-checking testbench for the circular-orbit
// delay table interpolator; depends on bdti_pkg and binary_delay_table_interp
module tb_binary_delay_table_interp;

   localparam int BINS = bdti_pkg::TABLE_BINS_DEF;
   localparam int AW = $clog2(BINS + 1);
   // drain wait, longer than the longest path through the block
   localparam int DRAIN_CYCLES = 140;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int RANDOM_BEATS = 55;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef struct {
      logic [1:0]         command;
      logic [AW-1:0]      index;
      logic signed [31:0] value;
      logic signed [63:0] arrival;
   } beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_command = bdti_pkg::CMD_EVAL;
   logic [AW-1:0] req_table_index = '0;
   logic signed [31:0] req_table_value = '0;
   logic signed [63:0] req_arrival_time = '0;
   logic rsp_valid;
   logic signed [63:0] rsp_corrected_time;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [bdti_pkg::CSR_IDX_W-1:0] csr_index = bdti_pkg::REG_PERIOD;
   logic [63:0] csr_wdata = '0;

   binary_delay_table_interp u_top (
      .clock(clock), .reset(reset),
      .start(start), .busy(busy),
      .req_command(req_command), .req_table_index(req_table_index),
      .req_table_value(req_table_value), .req_arrival_time(req_arrival_time),
      .rsp_valid(rsp_valid), .rsp_corrected_time(rsp_corrected_time),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // own copy of the block's state
   logic signed [31:0] cos_tab [0:BINS];
   logic signed [31:0] sin_tab [0:BINS];
   logic [62:0]        period_q;
   logic signed [63:0] cos_amp_q, sin_amp_q, drift_q, epoch_q;

   // entries already queued for writing, and the period the queued beats will see
   bit                 cos_planned [0:BINS];
   bit                 sin_planned [0:BINS];
   logic [62:0]        plan_period = bdti_pkg::PERIOD_RESET;

   beat_type           pending_beats[$];
   logic signed [63:0] expected_times[$];
   int                 sent_count = 0;
   int                 taken_count = 0;
   int                 idle_pct = 0;
   int                 error_count = 0;
   int                 quiet_cycles = 0;

   // linear interpolation, floored toward minus infinity
   function automatic logic signed [31:0] interp_entry(logic signed [31:0] lo,
                                                       logic signed [31:0] hi,
                                                       logic [31:0] frac);
      logic signed [33:0] d;
      logic signed [79:0] p;
      d = hi - lo;
      p = d * $signed({1'b0, frac});
      return lo + 32'(p >>> 32);
   endfunction

   // floor modulo so the phase lands in [0, period), scaled to bins and fraction
   function automatic logic [127:0] phase_pos(logic signed [63:0] t, logic [62:0] per);
      logic signed [65:0] rr;
      if (per == '0) return '0;
      rr = t % $signed({3'b000, per});
      if (rr < 0) rr = rr + $signed({3'b000, per});
      return ((128'(rr[62:0]) * 128'(BINS)) << 32) / 128'(per);
   endfunction

   function automatic int bin_of(logic [127:0] pos);
      int bin;
      bin = int'(pos >> 32);
      if (bin >= BINS) bin = BINS - 1;
      return bin;
   endfunction

   function automatic logic signed [63:0] corrected_time(logic signed [63:0] t);
      logic [127:0]        pos;
      logic [31:0]         frac;
      int                  bin;
      logic signed [31:0]  c_i, s_i;
      logic signed [191:0] acc, prod;
      pos = phase_pos(t, period_q);
      bin = int'(pos >> 32);
      frac = pos[31:0];
      if (bin >= BINS) begin
         bin = BINS - 1;
         frac = '1;
      end
      c_i = interp_entry(cos_tab[bin], cos_tab[bin+1], frac);
      s_i = interp_entry(sin_tab[bin], sin_tab[bin+1], frac);
      acc = t;
      prod = cos_amp_q * c_i;
      acc = acc + (prod >>> 30);
      prod = sin_amp_q * s_i;
      acc = acc + (prod >>> 30);
      prod = drift_q * (t - epoch_q);
      acc = acc - (prod >>> 63);
      // saturate to the signed 64-bit range
      if ((&acc[191:63]) || !(|acc[191:63])) return acc[63:0];
      return acc[191] ? 64'sh8000_0000_0000_0000 : 64'sh7fff_ffff_ffff_ffff;
   endfunction

   // driver: new beat at the falling edge once the previous one was taken
   always @(negedge clock) begin
      if (!start || taken_count == sent_count) begin
         if (pending_beats.size() > 0 && $urandom_range(99) >= idle_pct) begin
            beat_type b;
            b = pending_beats.pop_front();
            req_command <= b.command;
            req_table_index <= b.index;
            req_table_value <= b.value;
            req_arrival_time <= b.arrival;
            start <= 1'b1;
            sent_count <= sent_count + 1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: check results, then fold accepted beats into the predictor
   always @(posedge clock) begin
      if (reset) begin
         period_q <= bdti_pkg::PERIOD_RESET;
         cos_amp_q <= '0;
         sin_amp_q <= '0;
         drift_q <= '0;
         epoch_q <= '0;
      end else begin
         if (rsp_valid) begin
            if (expected_times.size() == 0) begin
               $error("unexpected result corrected_time=%h", rsp_corrected_time);
               error_count++;
            end else begin
               logic signed [63:0] want;
               want = expected_times.pop_front();
               if (want !== rsp_corrected_time) begin
                  $error("corrected_time expected %h actual %h", want, rsp_corrected_time);
                  error_count++;
               end
            end
         end
         if (start && !busy) begin
            taken_count <= taken_count + 1;
            case (req_command)
               bdti_pkg::CMD_EVAL:
                  expected_times.push_back(corrected_time(req_arrival_time));
               bdti_pkg::CMD_WR_COS:
                  if (req_table_index <= BINS) cos_tab[req_table_index] <= req_table_value;
               bdti_pkg::CMD_WR_SIN:
                  if (req_table_index <= BINS) sin_tab[req_table_index] <= req_table_value;
               default: ;
            endcase
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               bdti_pkg::REG_PERIOD:  period_q <= csr_wdata[62:0];
               bdti_pkg::REG_COS_AMP: cos_amp_q <= csr_wdata;
               bdti_pkg::REG_SIN_AMP: sin_amp_q <= csr_wdata;
               bdti_pkg::REG_DRIFT:   drift_q <= csr_wdata;
               bdti_pkg::REG_EPOCH:   epoch_q <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // watchdog on cycles with no beat moving anywhere
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic signed [31:0] rand_entry();
      case ($urandom_range(7))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic signed [63:0] rand_time();
      case ($urandom_range(4))
         0: return $signed(64'($urandom_range(16))) <<< 32;
         1: return -($signed(64'($urandom)) <<< $urandom_range(40));
         2: return $signed(64'($urandom)) <<< $urandom_range(32);
         default: return rand64();
      endcase
   endfunction

   // time whose phase falls near either end of the table, a few periods around zero
   function automatic logic signed [63:0] hot_time();
      logic [127:0]       base;
      logic [63:0]        off;
      logic signed [65:0] t;
      int                 b;
      int                 k;
      b = ($urandom_range(1) == 0) ? int'($urandom_range(3))
                                   : BINS - 1 - int'($urandom_range(3));
      base = (128'(plan_period) * 128'(b)) / 128'(BINS);
      off = 64'($urandom) % (64'(plan_period) / 64'(BINS) + 64'd1);
      k = (plan_period[62:61] != 2'b00) ? -int'($urandom_range(1))
                                         : int'($urandom_range(3)) - 2;
      t = $signed(66'(k)) * $signed({3'b000, plan_period})
          + $signed(66'(base[63:0])) + $signed({2'b00, off});
      return t[63:0];
   endfunction

   task automatic push_beat(logic [1:0] cmd, logic [AW-1:0] idx, logic signed [31:0] val,
                            logic signed [63:0] t);
      beat_type b;
      b.command = cmd;
      b.index = idx;
      b.value = val;
      b.arrival = t;
      pending_beats.push_back(b);
      if (idx <= AW'(BINS)) begin
         if (cmd == bdti_pkg::CMD_WR_COS) cos_planned[idx] = 1'b1;
         if (cmd == bdti_pkg::CMD_WR_SIN) sin_planned[idx] = 1'b1;
      end
   endtask

   // evaluate beat, preceded by writes of any neighbor entry not yet written
   task automatic push_eval(logic [AW-1:0] idx, logic signed [31:0] val,
                            logic signed [63:0] t);
      int b;
      b = bin_of(phase_pos(t, plan_period));
      for (int k = b; k <= b + 1; k++) begin
         if (!cos_planned[k]) push_beat(bdti_pkg::CMD_WR_COS, AW'(k), rand_entry(), rand64());
         if (!sin_planned[k]) push_beat(bdti_pkg::CMD_WR_SIN, AW'(k), rand_entry(), rand64());
      end
      push_beat(bdti_pkg::CMD_EVAL, idx, val, t);
   endtask

   task automatic push_random_beat();
      int pick;
      pick = $urandom_range(99);
      if (pick < 70)
         push_eval(AW'($urandom), $urandom,
                   ($urandom_range(3) == 0) ? rand_time() : hot_time());
      else if (pick < 94)
         // writes mostly in range, a few beyond the table end
         push_beat(pick < 82 ? bdti_pkg::CMD_WR_COS : bdti_pkg::CMD_WR_SIN,
                   ($urandom_range(9) == 0) ? AW'($urandom) : AW'($urandom_range(BINS)),
                   rand_entry(), rand64());
      else
         push_beat(CMD_UNUSED, AW'($urandom), $urandom, rand64());
   endtask

   // wait for every beat to be taken and every result to arrive, then let
   // table writes still in the pipe settle
   task automatic drain();
      while (pending_beats.size() > 0 || (start && taken_count != sent_count) ||
             expected_times.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [bdti_pkg::CSR_IDX_W-1:0] idx, logic [63:0] data);
      if (idx == bdti_pkg::REG_PERIOD) plan_period = data[62:0];
      @(negedge clock);
      csr_index <= idx;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic write_all_regs(logic [63:0] per, logic [63:0] ca, logic [63:0] sa,
                                 logic [63:0] dr, logic [63:0] ep);
      write_reg(bdti_pkg::REG_PERIOD, per);
      write_reg(bdti_pkg::REG_COS_AMP, ca);
      write_reg(bdti_pkg::REG_SIN_AMP, sa);
      write_reg(bdti_pkg::REG_DRIFT, dr);
      write_reg(bdti_pkg::REG_EPOCH, ep);
   endtask

   task automatic push_edge_times();
      push_eval('0, '0, 64'sh8000_0000_0000_0000);
      push_eval('1, '1, 64'sh7fff_ffff_ffff_ffff);
      push_eval('0, '0, 64'sd0);
      push_eval('0, '0, -64'sd1);
      push_eval('0, '0, 64'sh0000_0000_ffff_ffff);
   endtask

   initial begin
      int idle_plan [6] = '{0, 82, 0, 11, 82, 0};
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // seed both ends of the tables; other entries are written before first use
      for (int i = 0; i < 5; i++) begin
         push_beat(bdti_pkg::CMD_WR_COS, AW'(i), rand_entry(), rand64());
         push_beat(bdti_pkg::CMD_WR_SIN, AW'(i), rand_entry(), rand64());
         push_beat(bdti_pkg::CMD_WR_COS, AW'(BINS - i), rand_entry(), rand64());
         push_beat(bdti_pkg::CMD_WR_SIN, AW'(BINS - i), rand_entry(), rand64());
      end
      // reset registers: plain time pass-through
      push_edge_times();
      push_beat(bdti_pkg::CMD_WR_COS, AW'(BINS + 1), 32'sh1234_5678, '0);
      push_beat(bdti_pkg::CMD_WR_SIN, '1, 32'sh7654_3210, '0);
      push_beat(CMD_UNUSED, '0, '0, 64'sd5);
      drain();

      // extremes: largest period, full-scale amplitudes and drift
      write_all_regs(64'hffff_ffff_ffff_ffff, 64'h7fff_ffff_ffff_ffff,
                     64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000,
                     64'h7fff_ffff_ffff_ffff);
      push_edge_times();
      push_beat(bdti_pkg::CMD_WR_COS, AW'(BINS), 32'sh8000_0000, '0);
      push_eval('0, '0, 64'sh7fff_ffff_ffff_fffe);
      drain();

      // shortest period, then the zero-period case
      write_all_regs(64'd1, 64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff,
                     64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000);
      push_edge_times();
      drain();
      write_reg(bdti_pkg::REG_PERIOD, 64'd0);
      push_edge_times();
      drain();

      // random phases, each with its own register setting and idle pattern
      foreach (idle_plan[p]) begin
         write_all_regs((p % 2) ? rand64() : 64'($urandom_range(1, 64)) << $urandom_range(40),
                        $signed(64'($signed($urandom))) <<< $urandom_range(32),
                        (p == 3) ? rand64() : $signed(64'($signed($urandom))) <<< 2,
                        rand64(), rand_time());
         idle_pct = idle_plan[p];
         for (int n = 0; n < RANDOM_BEATS; n++) push_random_beat();
         drain();
      end

      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule
